>>> hw/rtl/peg_pkg.sv
// ============================================================================
// peg_pkg - shared types, constants and curve tables
// Command/status structs, FSM states, register indexes and the Q1.15
// exponential and sine tables for the pulse envelope generator.
// ============================================================================
package peg_pkg;

   localparam int CURVE_TABLE_DEPTH = 256;
   localparam int IDX_W = $clog2(CURVE_TABLE_DEPTH);

   // divider dividend width: elapsed * 32768 or elapsed * 3 * depth
   localparam int DIV_W_CURVE = 24 + $clog2(3 * CURVE_TABLE_DEPTH);
   localparam int DIV_W = (DIV_W_CURVE > 39) ? DIV_W_CURVE : 39;
   localparam int CNT_W = $clog2(DIV_W + 1);

   localparam logic [15:0] FULL_LEVEL   = 16'd32768;
   localparam logic [15:0] ACTIVE_FLOOR = 16'd327;
   localparam logic [20:0] WAVE_MAX     = 21'd1048576;

   localparam logic [63:0] Q30_ONE = 64'd1073741824;
   localparam logic [63:0] PI_Q30  = 64'd3373259426;

   typedef enum logic [2:0] {
      REG_MODE       = 3'd0,
      REG_ATTACK     = 3'd1,
      REG_DECAY      = 3'd2,
      REG_THRESHOLD  = 3'd3,
      REG_ROT_RATE   = 3'd4,
      REG_WAVE_RATE  = 3'd5,
      REG_BASE_ANGLE = 3'd6,
      REG_AUDIO_ROT  = 3'd7
   } peg_reg_type;

   typedef enum logic [1:0] {
      TRIG_CONT   = 2'd0,
      TRIG_BEAT   = 2'd1,
      TRIG_THRESH = 2'd2,
      TRIG_SPARE  = 2'd3
   } peg_trig_type;

   typedef enum logic [1:0] {
      CURVE_LINEAR = 2'd0,
      CURVE_EXP    = 2'd1,
      CURVE_HOLD   = 2'd2,
      CURVE_BOUNCE = 2'd3
   } peg_curve_type;

   typedef enum logic [1:0] {
      SEL_CONT = 2'd0,
      SEL_T15  = 2'd1,
      SEL_I    = 2'd2,
      SEL_J    = 2'd3
   } peg_sel_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_APPLY,
      ST_DIV_LOAD,
      ST_DIV_RUN,
      ST_CURVE,
      ST_EMIT
   } peg_state_type;

   typedef struct packed {
      logic        capture;
      logic        apply;
      logic        div_load;
      logic        div_store;
      peg_sel_type div_sel;
      logic        curve_fin;
      logic        out_load;
   } peg_cmd_type;

   typedef struct packed {
      logic need_div;
      logic need_curve;
      logic div_done;
   } peg_stat_type;

   typedef logic [15:0] curve_tab_type [CURVE_TABLE_DEPTH];

   function automatic logic [15:0] q30_to_q15(input logic [63:0] v);
      logic [63:0] r;
      r = (v + 64'd16384) >> 15;
      if (r > 64'(FULL_LEVEL)) r = 64'(FULL_LEVEL);
      return r[15:0];
   endfunction

   // exp(-num / depth) in Q30, series then six squarings
   // depth * 64 is a power of two, so the scaling is a shift
   function automatic logic [63:0] exp_neg_q30(input logic [63:0] num);
      logic [63:0] a, a2, a3, a4, e;
      a  = (num << 30) >> (IDX_W + 6);
      a2 = (a * a) >> 30;
      a3 = (a2 * a) >> 30;
      a4 = (a3 * a) >> 30;
      e  = Q30_ONE - a + a2 / 64'd2 - a3 / 64'd6 + a4 / 64'd24;
      for (int k = 0; k < 6; k++) e = (e * e) >> 30;
      return e;
   endfunction

   // sin(pi * k / depth) in Q30, Taylor series to the 11th power
   function automatic logic [63:0] sin_pi_q30(input logic [63:0] k);
      logic [63:0] m, th, th2, term;
      logic signed [63:0] s;
      m    = (k * 64'd2 > 64'(CURVE_TABLE_DEPTH)) ? 64'(CURVE_TABLE_DEPTH) - k : k;
      th   = (PI_Q30 * m) / 64'(CURVE_TABLE_DEPTH);
      th2  = (th * th) >> 30;
      term = th;
      s    = signed'(th);
      term = ((term * th2) >> 30) / 64'd6;   s = s - signed'(term);
      term = ((term * th2) >> 30) / 64'd20;  s = s + signed'(term);
      term = ((term * th2) >> 30) / 64'd42;  s = s - signed'(term);
      term = ((term * th2) >> 30) / 64'd72;  s = s + signed'(term);
      term = ((term * th2) >> 30) / 64'd110; s = s - signed'(term);
      return (s < 0) ? 64'd0 : unsigned'(s);
   endfunction

   function automatic curve_tab_type build_exp(input logic [63:0] rate);
      curve_tab_type tab;
      for (int k = 0; k < CURVE_TABLE_DEPTH; k++)
         tab[k] = q30_to_q15(exp_neg_q30(rate * 64'(k)));
      return tab;
   endfunction

   function automatic curve_tab_type build_sin();
      curve_tab_type tab;
      for (int k = 0; k < CURVE_TABLE_DEPTH; k++)
         tab[k] = q30_to_q15(sin_pi_q30(64'(k)));
      return tab;
   endfunction

   localparam curve_tab_type E5_TAB  = build_exp(64'd5);
   localparam curve_tab_type E3_TAB  = build_exp(64'd3);
   localparam curve_tab_type SIN_TAB = build_sin();

   // signed 18-bit rate saturated to +-65536
   function automatic logic signed [17:0] sat_rate(input logic [17:0] v);
      logic signed [17:0] x;
      x = signed'(v);
      if (x > 18'sd65536) x = 18'sd65536;
      if (x < -18'sd65536) x = -18'sd65536;
      return x;
   endfunction

endpackage

>>> hw/rtl/pulse_envelope_generator.sv
// ============================================================================
// pulse_envelope_generator - attack/decay and triggered pulse envelope
// Top level: stream in, stream out, register write port.
// ============================================================================
// Use:
//   req_* carries one transaction per item: a time tick (tuser = 0) with
//   elapsed time and audio level, or a beat trigger (tuser = 1) with strength.
//   Every accepted transaction returns exactly one rsp_* transaction holding
//   intensity, active flag, wave phase and rotation angle.
//   csr_* writes one register per handshake; write only while the block is
//   idle. csr_ready is always high.
// Sequencing:
//   Items are worked one at a time. A trigger or plain tick needs no
//   divider pass; a continuous-mode tick that ramps needs one; a tick
//   that continues a live pulse needs three passes of the 39-step
//   shift-subtract divider (curve position, table index, bounce index).
// Reset: synchronous, active high; clears the envelope state and registers
//   (threshold returns to full level). The curve tables are constants.
// Stall: the result waits in an output register; the next request is taken
//   meanwhile, and it stalls only when its own result is ready to load.
// ============================================================================
module pulse_envelope_generator
   import peg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,    // delta_time[15:0], level[31:16]
   input  logic        req_tuser,    // kind[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,    // intensity[15:0], active[16], phase[32:17],
                                     // rotation[48:33], zero[55:49]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [23:0] csr_data
);

   peg_cmd_type  cmd;
   peg_stat_type stat;
   logic [15:0]  intensity, phase, rotation;
   logic         active;

   assign csr_ready = 1'b1;
   assign rsp_tdata = {7'd0, rotation, phase, active, intensity};

   peg_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   peg_dpath u_dpath (
      .clock         (clock),
      .reset         (reset),
      .csr_valid     (csr_valid),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .in_kind       (req_tuser),
      .in_delta_time (req_tdata[15:0]),
      .in_level      (req_tdata[31:16]),
      .cmd           (cmd),
      .stat          (stat),
      .out_intensity (intensity),
      .out_active    (active),
      .out_phase     (phase),
      .out_rotation  (rotation)
   );

endmodule

>>> hw/rtl/peg_ctrl.sv
// ============================================================================
// peg_ctrl - sequencing state machine
// Accepts one transaction at a time, steps the datapath through the update,
// the divider passes and the curve lookup, and owns the result valid flag.
// ============================================================================
module peg_ctrl
   import peg_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  peg_stat_type stat,
   output peg_cmd_type  cmd
);

   peg_state_type state_ff, state_in;
   peg_sel_type   sel_ff, sel_in;
   logic          out_valid_ff, out_valid_in;
   logic          out_free;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign rsp_tvalid = out_valid_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      sel_in   = sel_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_APPLY;
         end
         ST_APPLY: begin
            if (stat.need_div) begin
               state_in = ST_DIV_LOAD;
               sel_in   = SEL_CONT;
            end else if (stat.need_curve) begin
               state_in = ST_DIV_LOAD;
               sel_in   = SEL_T15;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_DIV_LOAD: state_in = ST_DIV_RUN;
         ST_DIV_RUN: begin
            if (stat.div_done) begin
               case (sel_ff)
                  SEL_CONT: state_in = ST_EMIT;
                  SEL_T15: begin
                     state_in = ST_DIV_LOAD;
                     sel_in   = SEL_I;
                  end
                  SEL_I: begin
                     state_in = ST_DIV_LOAD;
                     sel_in   = SEL_J;
                  end
                  default: state_in = ST_CURVE;
               endcase
            end
         end
         ST_CURVE: state_in = ST_EMIT;
         ST_EMIT: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd          = '0;
      cmd.div_sel  = sel_ff;
      req_tready   = 1'b0;
      out_valid_in = out_valid_ff && !rsp_tready;
      case (state_ff)
         ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
         end
         ST_APPLY:    cmd.apply = 1'b1;
         ST_DIV_LOAD: cmd.div_load = 1'b1;
         ST_DIV_RUN:  cmd.div_store = stat.div_done;
         ST_CURVE:    cmd.curve_fin = 1'b1;
         ST_EMIT: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               out_valid_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sel_ff       <= SEL_CONT;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sel_ff       <= sel_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // a waiting result is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!out_valid_ff || rsp_tready))
      else $error("result register overwritten");

   // an accepted transaction always goes to the update step next
   a_accept_apply: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == ST_APPLY))
      else $error("accept not followed by update");

   // a divider pass never completes in the cycle after it is loaded
   a_div_runs: assert property (@(posedge clock) disable iff (reset)
      cmd.div_load |=> !stat.div_done)
      else $error("divider done right after load");

   // one result per transaction: after loading a result we go back to idle
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> (state_ff == ST_IDLE && rsp_tvalid))
      else $error("result load without return to idle");

endmodule

>>> hw/rtl/peg_dpath.sv
// ============================================================================
// peg_dpath - envelope datapath
// Configuration registers, envelope state, shift-subtract divider, curve
// tables and the result register.
// ============================================================================
module peg_dpath
   import peg_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_valid,
   input  logic [2:0]   csr_index,
   input  logic [23:0]  csr_data,
   input  logic         in_kind,
   input  logic [15:0]  in_delta_time,
   input  logic [15:0]  in_level,
   input  peg_cmd_type  cmd,
   output peg_stat_type stat,
   output logic [15:0]  out_intensity,
   output logic         out_active,
   output logic [15:0]  out_phase,
   output logic [15:0]  out_rotation
);

   // configuration
   logic [3:0]  mode_ff;
   logic [23:0] attack_ff, decay_ff;
   logic [15:0] thresh_ff, base_ff;
   logic [17:0] rot_rate_ff, audio_rot_ff;
   logic [20:0] wave_rate_ff;

   // captured transaction
   logic        kind_ff;
   logic [15:0] dt_ff, lvl_ff;

   // envelope state
   logic [15:0] level_ff, level_in;
   logic        live_ff, live_in;
   logic [23:0] elapsed_ff, elapsed_in;
   logic [15:0] spin_ff, spin_in;
   logic [15:0] wave_ff, wave_in;
   logic [15:0] last_ff, last_in;
   logic        up_ff, up_in;

   // divider and curve operands
   logic [DIV_W-1:0] quo_ff, quo_in;
   logic [24:0]      rem_ff, rem_in;
   logic [23:0]      den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [15:0]      t15_ff, t15_in;
   logic [IDX_W-1:0] idx_i_ff, idx_i_in, idx_j_ff, idx_j_in;

   peg_trig_type  trig;
   peg_curve_type curve;
   logic          up, dn, fire_t, live_n, ends;
   logic [23:0]   base_e, e_new;
   logic [24:0]   e_sum;
   logic signed [34:0] spin_prod, spin_mag;
   logic [15:0]   spin_step;
   logic [20:0]   wave_rate_sat;
   logic [36:0]   wave_prod;
   logic [24:0]   shifted;
   logic          ge;
   logic [DIV_W-1:0] dividend;
   logic [15:0]   room, cont_lvl;
   logic [IDX_W+1:0] jr, j1, j2;
   logic [31:0]   bounce_prod;
   logic [15:0]   curve_lvl;
   logic signed [34:0] audio, audio_mag;
   logic [15:0]   audio_term;

   assign trig  = peg_trig_type'(mode_ff[3:2]);
   assign curve = peg_curve_type'(mode_ff[1:0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= '0;
         attack_ff    <= '0;
         decay_ff     <= '0;
         thresh_ff    <= FULL_LEVEL;
         rot_rate_ff  <= '0;
         wave_rate_ff <= '0;
         base_ff      <= '0;
         audio_rot_ff <= '0;
      end else if (csr_valid) begin
         case (peg_reg_type'(csr_index))
            REG_MODE:       mode_ff      <= csr_data[3:0];
            REG_ATTACK:     attack_ff    <= csr_data;
            REG_DECAY:      decay_ff     <= csr_data;
            REG_THRESHOLD:  thresh_ff    <= csr_data[15:0];
            REG_ROT_RATE:   rot_rate_ff  <= csr_data[17:0];
            REG_WAVE_RATE:  wave_rate_ff <= csr_data[20:0];
            REG_BASE_ANGLE: base_ff      <= csr_data[15:0];
            REG_AUDIO_ROT:  audio_rot_ff <= csr_data[17:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff <= in_kind;
         dt_ff   <= in_delta_time;
         lvl_ff  <= (in_level > FULL_LEVEL) ? FULL_LEVEL : in_level;
      end
   end

   // update-step decisions
   always_comb begin
      up      = (attack_ff != '0) && (lvl_ff > level_ff);
      dn      = !up && (decay_ff != '0) && (lvl_ff < level_ff);
      fire_t  = (trig == TRIG_THRESH) && (lvl_ff >= thresh_ff) && !live_ff;
      live_n  = live_ff || fire_t;
      base_e  = fire_t ? '0 : elapsed_ff;
      e_sum   = {1'b0, base_e} + {9'd0, dt_ff};
      e_new   = e_sum[24] ? '1 : e_sum[23:0];
      ends    = e_new >= decay_ff;
      stat.need_div   = !kind_ff && (trig == TRIG_CONT) && (up || dn);
      stat.need_curve = !kind_ff && (trig != TRIG_CONT) && live_n && !ends;
      stat.div_done   = (cnt_ff == '0);
   end

   // spin and wave steps; spin truncates toward zero
   always_comb begin
      spin_prod     = sat_rate(rot_rate_ff) * signed'({1'b0, dt_ff});
      spin_mag      = (spin_prod < 0) ? -spin_prod : spin_prod;
      spin_step     = (spin_prod < 0) ? 16'(-(spin_mag >>> 16)) : 16'(spin_mag >>> 16);
      wave_rate_sat = (wave_rate_ff > WAVE_MAX) ? WAVE_MAX : wave_rate_ff;
      wave_prod     = {16'd0, wave_rate_sat} * {21'd0, dt_ff};
   end

   // divider step and operand selection
   always_comb begin
      shifted = {rem_ff[23:0], quo_ff[DIV_W-1]};
      ge      = shifted >= {1'b0, den_ff};
      case (cmd.div_sel)
         SEL_CONT: dividend = DIV_W'({dt_ff, 15'd0});
         SEL_T15:  dividend = DIV_W'({elapsed_ff, 15'd0});
         SEL_I:    dividend = DIV_W'(elapsed_ff) * DIV_W'(CURVE_TABLE_DEPTH);
         default:  dividend = DIV_W'(elapsed_ff) * DIV_W'(3 * CURVE_TABLE_DEPTH);
      endcase
   end

   // continuous-mode result and bounce table index from the quotient
   always_comb begin
      room = up_ff ? (lvl_ff - level_ff) : (level_ff - lvl_ff);
      if (quo_ff >= DIV_W'(room)) cont_lvl = lvl_ff;
      else if (up_ff)             cont_lvl = level_ff + quo_ff[15:0];
      else                        cont_lvl = level_ff - quo_ff[15:0];
      jr = quo_ff[IDX_W+1:0];
      j1 = (jr >= (IDX_W+2)'(CURVE_TABLE_DEPTH)) ? jr - (IDX_W+2)'(CURVE_TABLE_DEPTH) : jr;
      j2 = (j1 >= (IDX_W+2)'(CURVE_TABLE_DEPTH)) ? j1 - (IDX_W+2)'(CURVE_TABLE_DEPTH) : j1;
   end

   // curve value from stored quotients
   always_comb begin
      bounce_prod = {16'd0, E3_TAB[idx_i_ff]} * {16'd0, SIN_TAB[idx_j_ff]};
      case (curve)
         CURVE_LINEAR: curve_lvl = FULL_LEVEL - t15_ff;
         CURVE_EXP:    curve_lvl = E5_TAB[idx_i_ff];
         CURVE_HOLD:   curve_lvl = (t15_ff < 16'd16384) ? FULL_LEVEL : 16'(17'd65536 - {t15_ff, 1'b0});
         default:      curve_lvl = bounce_prod[30:15];
      endcase
   end

   // state next values
   always_comb begin
      level_in   = level_ff;
      live_in    = live_ff;
      elapsed_in = elapsed_ff;
      spin_in    = spin_ff;
      wave_in    = wave_ff;
      last_in    = last_ff;
      up_in      = up_ff;
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      den_in     = den_ff;
      cnt_in     = cnt_ff;
      t15_in     = t15_ff;
      idx_i_in   = idx_i_ff;
      idx_j_in   = idx_j_ff;

      if (cmd.apply) begin
         up_in = up;
         if (kind_ff) begin
            live_in    = 1'b1;
            level_in   = lvl_ff;
            elapsed_in = '0;
         end else begin
            last_in = lvl_ff;
            spin_in = spin_ff + spin_step;
            wave_in = wave_ff + wave_prod[31:16];
            if (trig == TRIG_CONT) begin
               if (!(up || dn)) begin
                  level_in = lvl_ff;
                  live_in  = lvl_ff > ACTIVE_FLOOR;
               end
            end else if (live_n) begin
               elapsed_in = e_new;
               live_in    = !ends;
               level_in   = ends ? '0 : lvl_ff;
            end
         end
      end

      if (cmd.div_load) begin
         quo_in = dividend;
         rem_in = '0;
         den_in = (cmd.div_sel == SEL_CONT && up_ff) ? attack_ff : decay_ff;
         cnt_in = CNT_W'(DIV_W);
      end else if (cnt_ff != '0) begin
         rem_in = ge ? shifted - {1'b0, den_ff} : shifted;
         quo_in = {quo_ff[DIV_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
      end

      if (cmd.div_store) begin
         case (cmd.div_sel)
            SEL_CONT: begin
               level_in = cont_lvl;
               live_in  = cont_lvl > ACTIVE_FLOOR;
            end
            SEL_T15: t15_in   = quo_ff[15:0];
            SEL_I:   idx_i_in = quo_ff[IDX_W-1:0];
            default: idx_j_in = j2[IDX_W-1:0];
         endcase
      end

      if (cmd.curve_fin) level_in = curve_lvl;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff   <= '0;
         live_ff    <= 1'b0;
         elapsed_ff <= '0;
         spin_ff    <= '0;
         wave_ff    <= '0;
         last_ff    <= '0;
         cnt_ff     <= '0;
      end else begin
         level_ff   <= level_in;
         live_ff    <= live_in;
         elapsed_ff <= elapsed_in;
         spin_ff    <= spin_in;
         wave_ff    <= wave_in;
         last_ff    <= last_in;
         cnt_ff     <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      up_ff    <= up_in;
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      den_ff   <= den_in;
      t15_ff   <= t15_in;
      idx_i_ff <= idx_i_in;
      idx_j_ff <= idx_j_in;
   end

   // rotation: audio term truncates toward zero
   always_comb begin
      audio      = signed'({2'b00, last_ff}) * 35'(sat_rate(audio_rot_ff));
      audio_mag  = (audio < 0) ? -audio : audio;
      audio_term = (audio < 0) ? 16'(-(audio_mag >>> 15)) : 16'(audio_mag >>> 15);
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_intensity <= level_ff;
         out_active    <= live_ff;
         out_phase     <= wave_ff;
         out_rotation  <= base_ff + spin_ff + audio_term;
      end
   end

endmodule

>>> verif/pulse_envelope_generator_test.sv
// ============================================================================
// pulse_envelope_generator_test - self-checking stream testbench
// Drives ticks and beat triggers through all envelope modes and register
// settings. A scoreboard class predicts every result from its own copy of the
// envelope state and compares it field by field with the rsp transaction.
// ============================================================================
module pulse_envelope_generator_test
   import peg_pkg::*;
();

   localparam bit KIND_TICK = 1'b0;
   localparam bit KIND_BEAT = 1'b1;
   localparam int CYCLE_LIMIT = 2000000;
   localparam int DRAIN_CYCLES = 200;   // outlasts the longest item
   localparam int RANDOM_PHASES = 29;
   localparam int PHASE_ITEMS = 25;

   // -------------------------------------------------------------------------
   // Scoreboard: envelope predictor plus queue of pending results
   // -------------------------------------------------------------------------
   class envelope_scoreboard_type;
      typedef struct packed {
         logic [6:0]  pad;
         logic [15:0] rotation;
         logic [15:0] phase;
         logic        active;
         logic [15:0] intensity;
      } result_type;

      result_type       pending_results[$];
      int               errors;
      int               checked;
      logic [15:0]      e5_tab[256], e3_tab[256], sin_tab[256];
      // registers
      logic [3:0]       mode_r;
      logic [23:0]      attack_r, decay_r;
      logic [15:0]      thresh_r, base_r;
      logic [17:0]      rot_rate_r, audio_scale_r;
      logic [20:0]      wave_rate_r;
      // envelope state
      logic [15:0]      level_q, spin_q, phase_q, last_level_q;
      logic             live_q;
      logic [23:0]      elapsed_q;

      function longint unsigned to_q15(longint unsigned v);
         longint unsigned r;
         r = (v + 16384) >> 15;
         return (r > 32768) ? 32768 : r;
      endfunction

      function longint unsigned exp_q30(longint unsigned num);
         longint unsigned a, a2, a3, a4, e;
         a  = (num << 30) / (256 * 64);
         a2 = (a * a) >> 30;
         a3 = (a2 * a) >> 30;
         a4 = (a3 * a) >> 30;
         e  = 64'd1073741824 - a + a2 / 2 - a3 / 6 + a4 / 24;
         repeat (6) e = (e * e) >> 30;
         return e;
      endfunction

      function longint unsigned sin_q30(longint unsigned k);
         longint unsigned m, th, th2, term;
         longint          s;
         m    = (k * 2 > 256) ? 256 - k : k;
         th   = (64'd3373259426 * m) / 256;
         th2  = (th * th) >> 30;
         term = th;
         s    = th;
         for (int n = 1; n <= 5; n++) begin
            term = ((term * th2) >> 30) / ((2 * n) * (2 * n + 1));
            if (n % 2) s = s - longint'(term);
            else s = s + longint'(term);
         end
         return (s < 0) ? 0 : s;
      endfunction

      function new();
         for (int k = 0; k < 256; k++) begin
            e5_tab[k]  = 16'(to_q15(exp_q30(5 * k)));
            e3_tab[k]  = 16'(to_q15(exp_q30(3 * k)));
            sin_tab[k] = 16'(to_q15(sin_q30(k)));
         end
         mode_r = '0; attack_r = '0; decay_r = '0; thresh_r = 16'd32768; base_r = '0;
         rot_rate_r = '0; audio_scale_r = '0; wave_rate_r = '0;
         level_q = '0; spin_q = '0; phase_q = '0; last_level_q = '0;
         live_q = 1'b0; elapsed_q = '0;
         errors = 0; checked = 0;
      endfunction

      function longint sat_rate(logic [17:0] v);
         longint x;
         x = longint'(signed'(v));
         if (x > 65536) x = 65536;
         if (x < -65536) x = -65536;
         return x;
      endfunction

      function void write_reg(peg_reg_type idx, logic [23:0] value);
         case (idx)
            REG_MODE:       mode_r = value[3:0];
            REG_ATTACK:     attack_r = value;
            REG_DECAY:      decay_r = value;
            REG_THRESHOLD:  thresh_r = value[15:0];
            REG_ROT_RATE:   rot_rate_r = value[17:0];
            REG_WAVE_RATE:  wave_rate_r = value[20:0];
            REG_BASE_ANGLE: base_r = value[15:0];
            REG_AUDIO_ROT:  audio_scale_r = value[17:0];
            default: ;
         endcase
      endfunction

      function void start_pulse(logic [15:0] lvl);
         live_q = 1'b1; level_q = lvl; elapsed_q = '0;
      endfunction

      function logic [15:0] curve_point();
         longint unsigned t15, i, j;
         peg_curve_type   curve;
         t15   = (longint'(elapsed_q) * 32768) / decay_r;
         i     = (longint'(elapsed_q) * 256) / decay_r;
         j     = ((longint'(elapsed_q) * 768) / decay_r) % 256;
         if (i > 255) i = 255;
         curve = peg_curve_type'(mode_r[1:0]);
         case (curve)
            CURVE_LINEAR: return 16'(32768 - t15);
            CURVE_EXP:    return e5_tab[i];
            CURVE_HOLD:   return (t15 < 16384) ? 16'd32768 : 16'(65536 - 2 * t15);
            default:      return 16'((longint'(e3_tab[i]) * sin_tab[j]) >> 15);
         endcase
      endfunction

      // one accepted request -> one expected result
      function void note_request(logic kind, logic [15:0] dt, logic [15:0] raw_lvl);
         logic [15:0]     lvl;
         longint          sp, step, audio, term;
         longint unsigned delta, room, wr, e;
         peg_trig_type    trig;
         result_type      r;
         lvl  = (raw_lvl > 16'd32768) ? 16'd32768 : raw_lvl;
         trig = peg_trig_type'(mode_r[3:2]);
         if (kind == KIND_BEAT) begin
            start_pulse(lvl);
         end else begin
            sp   = sat_rate(rot_rate_r) * longint'(dt);
            step = (sp < 0) ? -((-sp) >>> 16) : (sp >>> 16);
            wr   = (wave_rate_r > 21'd1048576) ? 1048576 : wave_rate_r;
            last_level_q = lvl;
            spin_q = spin_q + step[15:0];
            if (trig == TRIG_CONT) begin
               if (attack_r > 0 && lvl > level_q) begin
                  delta = (longint'(dt) * 32768) / attack_r;
                  level_q = (level_q + delta > lvl) ? lvl : 16'(level_q + delta);
               end else if (decay_r > 0 && lvl < level_q) begin
                  delta = (longint'(dt) * 32768) / decay_r;
                  room  = level_q - lvl;
                  level_q = (delta >= room) ? lvl : 16'(level_q - delta);
               end else begin
                  level_q = lvl;
               end
               live_q = (level_q > 16'd327);
            end else begin
               if (trig == TRIG_THRESH && lvl >= thresh_r && !live_q) start_pulse(lvl);
               if (live_q) begin
                  e = longint'(elapsed_q) + dt;
                  elapsed_q = (e > 24'hFFFFFF) ? 24'hFFFFFF : 24'(e);
                  if (elapsed_q >= decay_r) begin
                     live_q = 1'b0; level_q = '0;
                  end else begin
                     level_q = curve_point();
                  end
               end
            end
            phase_q = 16'(phase_q + ((wr * dt) >> 16));
         end
         audio = longint'(last_level_q) * sat_rate(audio_scale_r);
         term  = (audio < 0) ? -((-audio) >>> 15) : (audio >>> 15);
         r.pad       = '0;
         r.intensity = level_q;
         r.active    = live_q;
         r.phase     = phase_q;
         r.rotation  = base_r + spin_q + term[15:0];
         pending_results.insert(pending_results.size(), r);
      endfunction

      function void check_result(logic [55:0] data);
         result_type got, want;
         got = data;
         checked++;
         if (pending_results.size() == 0) begin
            $display("%0t: result with none expected: %h", $time, data);
            errors++;
            return;
         end
         want = pending_results.pop_front();
         if (got.intensity !== want.intensity) begin
            $display("%0t: intensity expected %0d actual %0d", $time, want.intensity,
                     got.intensity);
            errors++;
         end
         if (got.active !== want.active) begin
            $display("%0t: active expected %0d actual %0d", $time, want.active, got.active);
            errors++;
         end
         if (got.phase !== want.phase) begin
            $display("%0t: phase expected %0d actual %0d", $time, want.phase, got.phase);
            errors++;
         end
         if (got.rotation !== want.rotation) begin
            $display("%0t: rotation expected %0d actual %0d", $time, want.rotation,
                     got.rotation);
            errors++;
         end
         if (got.pad !== want.pad) begin
            $display("%0t: pad bits expected %h actual %h", $time, want.pad, got.pad);
            errors++;
         end
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // DUT hookup
   // -------------------------------------------------------------------------
   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [31:0] req_tdata = 0;    // delta_time[15:0], level[31:16]
   logic        req_tuser = 0;    // kind[0]
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [55:0] rsp_tdata;        // intensity, active, phase, rotation, zero pad
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [2:0]  csr_index = 0;
   logic [23:0] csr_data = 0;

   envelope_scoreboard_type env_sb = new();
   int cycles = 0;
   int items_sent = 0;
   int phases_run = 0;

   pulse_envelope_generator dut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycles);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // result side: check every rsp transaction, random backpressure
   int stall_left = 0;
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) env_sb.check_result(rsp_tdata);
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 0;
      end else begin
         rsp_tready <= 1;
         if ($urandom_range(0, 3) == 0)
            stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                      : $urandom_range(1, 3);
      end
   end

   // gap length: mostly none or short, occasionally long
   function int pick_gap();
      int roll;
      roll = $urandom_range(0, 19);
      if (roll < 10) return 0;
      if (roll < 19) return $urandom_range(1, 4);
      return $urandom_range(10, 60);
   endfunction

   // csr_valid stays high across back-to-back writes; caller lowers it
   task automatic write_csr(peg_reg_type idx, logic [23:0] value);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      env_sb.write_reg(idx, value);
   endtask

   task automatic send_item(logic kind, logic [15:0] dt, logic [15:0] lvl);
      int gap;
      req_tvalid <= 1;
      req_tuser  <= kind;
      req_tdata  <= {lvl, dt};
      do @(posedge clock); while (!req_tready);
      env_sb.note_request(kind, dt, lvl);
      items_sent++;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // wait for all results, let the block settle, then load a full register set
   task automatic configure(logic [3:0] mode, logic [23:0] attack, logic [23:0] decay,
                            logic [15:0] thresh, logic [23:0] rot, logic [23:0] wave,
                            logic [15:0] base, logic [23:0] audio);
      req_tvalid <= 0;
      while (env_sb.pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      write_csr(REG_MODE, 24'(mode));
      write_csr(REG_ATTACK, attack);
      write_csr(REG_DECAY, decay);
      write_csr(REG_THRESHOLD, 24'(thresh));
      write_csr(REG_ROT_RATE, rot);
      write_csr(REG_WAVE_RATE, wave);
      write_csr(REG_BASE_ANGLE, 24'(base));
      write_csr(REG_AUDIO_ROT, audio);
      csr_valid <= 0;
      phases_run++;
   endtask

   function logic [23:0] pick_time();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return 24'hFFFFFF;
         2: return 24'($urandom_range(1, 255));
         3: return 24'($urandom);
         default: return 24'($urandom_range(256, 400000));
      endcase
   endfunction

   function logic [23:0] pick_rate();
      case ($urandom_range(0, 4))
         0: return 24'h010000;            // +65536
         1: return 24'h030000;            // -65536 in 18 bits
         2: return 24'($urandom);         // anything, saturates if out of range
         default: return 24'($urandom_range(0, 24'h03FFFF));
      endcase
   endfunction

   function logic [15:0] pick_level();
      return ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 65535))
                                         : 16'($urandom_range(0, 32768));
   endfunction

   // delta time scaled to the decay time so pulses span several ticks
   function logic [15:0] pick_dt();
      int unsigned span;
      span = env_sb.decay_r / 6 + 1;
      if (span > 65535) span = 65535;
      return ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 65535))
                                         : 16'($urandom_range(0, span));
   endfunction

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------
   initial begin
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // continuous follow, extreme rates and offsets
      configure({TRIG_CONT, CURVE_LINEAR}, 24'h010000, 24'h008000, 16'd32768,
                24'h010000, 24'h100000, 16'hFFFF, 24'h030000);
      send_item(KIND_TICK, 16'd0, 16'd0);
      send_item(KIND_TICK, 16'hFFFF, 16'd32768);
      send_item(KIND_TICK, 16'hFFFF, 16'hFFFF);          // level above one
      send_item(KIND_TICK, 16'd100, 16'd0);
      send_item(KIND_BEAT, 16'hFFFF, 16'd40000);
      send_item(KIND_TICK, 16'hFFFF, 16'd0);

      // out of range rates, instant attack and decay
      configure({TRIG_CONT, CURVE_EXP}, 24'd0, 24'd0, 16'd0,
                24'h01FFFF, 24'h1FFFFF, 16'd0, 24'h020000);
      send_item(KIND_TICK, 16'hFFFF, 16'd20000);
      send_item(KIND_TICK, 16'h8000, 16'd100);

      // beat mode, every curve, then zero decay time
      for (int c = 0; c < 4; c++) begin
         configure({TRIG_BEAT, 2'(c)}, 24'd0, 24'd1000, 16'd32768,
                   24'h000100, 24'd7, 16'd1234, 24'h00FFFF);
         send_item(KIND_BEAT, 16'd0, 16'd32768);
         send_item(KIND_TICK, 16'd300, 16'd5);
         send_item(KIND_TICK, 16'd400, 16'd5);
         send_item(KIND_TICK, 16'd400, 16'd5);           // past decay: pulse ends
      end
      configure({TRIG_SPARE, CURVE_HOLD}, 24'd0, 24'd0, 16'd32768, '0, '0, '0, '0);
      send_item(KIND_BEAT, 16'd0, 16'd30000);
      send_item(KIND_TICK, 16'd0, 16'd0);

      // threshold firing; threshold above one never fires
      configure({TRIG_THRESH, CURVE_LINEAR}, 24'd0, 24'd5000, 16'd20000, '0, '0, '0, '0);
      send_item(KIND_TICK, 16'd100, 16'd19999);
      send_item(KIND_TICK, 16'd100, 16'd20000);
      send_item(KIND_TICK, 16'd100, 16'd0);
      configure({TRIG_THRESH, CURVE_BOUNCE}, 24'hFFFFFF, 24'hFFFFFF, 16'd40000,
                '0, '0, '0, '0);
      send_item(KIND_TICK, 16'd100, 16'hFFFF);
      send_item(KIND_BEAT, 16'd0, 16'd1);
      send_item(KIND_TICK, 16'hFFFF, 16'd1);

      // random phases: mostly triggered pulses with ticks, some continuous
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         configure(4'($urandom_range(0, 15)), pick_time(), pick_time(),
                   ($urandom_range(0, 5) == 0) ? 16'($urandom_range(0, 65535))
                                               : 16'($urandom_range(0, 32768)),
                   pick_rate(),
                   24'($urandom_range(0, 24'hFFFFFF) >> $urandom_range(0, 3)),
                   16'($urandom_range(0, 65535)), pick_rate());
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if ($urandom_range(0, 5) == 0)
               send_item(KIND_BEAT, 16'($urandom_range(0, 65535)), pick_level());
            else
               send_item(KIND_TICK, pick_dt(), pick_level());
         end
      end

      req_tvalid <= 0;
      while (env_sb.pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d register phases over all trigger modes and curves,", phases_run);
      $display("%0d requests sent, %0d results checked, %0d mismatches",
               items_sent, env_sb.checked, env_sb.errors);
      if (env_sb.errors == 0 && env_sb.pending_results.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

>>> filelist.f
hw/rtl/peg_pkg.sv
hw/rtl/peg_ctrl.sv
hw/rtl/peg_dpath.sv
hw/rtl/pulse_envelope_generator.sv
verif/pulse_envelope_generator_test.sv
